[rtl/rsm_pkg.sv]
// Shared types, constants and decode helpers for the register stack machine core.
package rsm_pkg;

    localparam int MEM_DEPTH  = 1024;
    localparam int REG_COUNT  = 16;
    localparam int FILE_DEPTH = 256;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam int FILE_AW    = $clog2(FILE_DEPTH);
    localparam int REG_AW     = $clog2(REG_COUNT);
    localparam int OPCODE_MAX = 22;

    // Step operations.
    localparam logic [1:0] OPN_MEM_WR  = 2'd0;
    localparam logic [1:0] OPN_FILE_WR = 2'd1;
    localparam logic [1:0] OPN_EXEC    = 2'd2;
    localparam logic [1:0] OPN_RESTART = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_OUTPUT = 2'd1;
    localparam logic [1:0] ST_HALTED = 2'd2;
    localparam logic [1:0] ST_FAULT  = 2'd3;

    // Fault codes.
    localparam logic [2:0] F_NONE  = 3'd0;
    localparam logic [2:0] F_PC    = 3'd1;
    localparam logic [2:0] F_OPC   = 3'd2;
    localparam logic [2:0] F_STACK = 3'd3;
    localparam logic [2:0] F_FILE  = 3'd4;
    localparam logic [2:0] F_DADDR = 3'd5;
    localparam logic [2:0] F_REG   = 3'd6;

    // Run status.
    localparam logic [1:0] RUN_RUNNING = 2'd0;
    localparam logic [1:0] RUN_HALTED  = 2'd1;
    localparam logic [1:0] RUN_FAULTED = 2'd2;

    // Opcodes.
    localparam logic [4:0] OP_LOAD  = 5'd1;
    localparam logic [4:0] OP_STORE = 5'd2;
    localparam logic [4:0] OP_READ  = 5'd3;
    localparam logic [4:0] OP_WRITE = 5'd4;
    localparam logic [4:0] OP_COPY  = 5'd5;
    localparam logic [4:0] OP_NEG   = 5'd6;
    localparam logic [4:0] OP_SUB   = 5'd7;
    localparam logic [4:0] OP_ADD   = 5'd8;
    localparam logic [4:0] OP_AND   = 5'd9;
    localparam logic [4:0] OP_OR    = 5'd10;
    localparam logic [4:0] OP_XOR   = 5'd11;
    localparam logic [4:0] OP_NOT   = 5'd12;
    localparam logic [4:0] OP_JMP   = 5'd13;
    localparam logic [4:0] OP_JZ    = 5'd14;
    localparam logic [4:0] OP_JNZ   = 5'd15;
    localparam logic [4:0] OP_JN    = 5'd16;
    localparam logic [4:0] OP_JNN   = 5'd17;
    localparam logic [4:0] OP_PUSH  = 5'd18;
    localparam logic [4:0] OP_POP   = 5'd19;
    localparam logic [4:0] OP_CALL  = 5'd20;
    localparam logic [4:0] OP_RET   = 5'd21;
    localparam logic [4:0] OP_HALT  = 5'd22;

    typedef struct packed {
        logic [1:0]         operation;
        logic [9:0]         address;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [2:0]         fault_code;
        logic signed [31:0] out_value;
        logic [9:0]         program_counter;
    } t_out;

    // Strobes from the controller, one per sequencer step except output.
    typedef struct packed {
        logic clear;
        logic accept;
        logic fetch;
        logic opc;
        logic opa;
        logic opb;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic early_fault;
        logic running;
    } t_stat;

    // PC advance of an instruction: its word count, or zero for RET and HALT.
    function automatic logic [1:0] advance_of(input logic [4:0] op);
        logic [1:0] n;
        case (op)
            OP_LOAD, OP_STORE, OP_COPY, OP_SUB, OP_ADD, OP_AND, OP_OR,
            OP_XOR: n = 2'd3;
            OP_RET, OP_HALT: n = 2'd0;
            default: n = 2'd2;
        endcase
        return n;
    endfunction

endpackage

[rtl/rsm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

[rtl/rsm_ctrl.sv]
// Sequencer that steps the datapath through clearing, fetch, execute and output.
module rsm_ctrl
    import rsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_op,
    input  logic       i_out_ready,
    input  t_stat      i_stat,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_OPC   = 3'd3;
    localparam logic [2:0] S_OPA   = 3'd4;
    localparam logic [2:0] S_OPB   = 3'd5;
    localparam logic [2:0] S_EXEC  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] r_state, n_state;
    logic       accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign accept      = o_in_ready && i_in_valid;

    always_comb begin
        o_cmd        = '0;
        o_cmd.clear  = (r_state == S_CLEAR);
        o_cmd.accept = accept;
        o_cmd.fetch  = (r_state == S_FETCH);
        o_cmd.opc    = (r_state == S_OPC);
        o_cmd.opa    = (r_state == S_OPA);
        o_cmd.opb    = (r_state == S_OPB);
        o_cmd.exec   = (r_state == S_EXEC);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_op == OPN_EXEC && i_stat.running) ? S_FETCH : S_OUT;
                end
            end
            S_FETCH: n_state = S_OPC;
            S_OPC: begin
                n_state = i_stat.early_fault ? S_OUT : S_OPA;
            end
            S_OPA:  n_state = S_OPB;
            S_OPB:  n_state = S_EXEC;
            S_EXEC: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and valid together");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready) else $error("ready right after accept");
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> !o_out_valid) else $error("result repeated");
    a_exec_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> o_out_valid) else $error("execute without result");
endmodule

[rtl/rsm_dp.sv]
// Datapath: architectural registers, memories, decode checks and result register.
module rsm_dp
    import rsm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_in  i_in,
    output t_stat o_stat,
    output t_out o_out
);
    logic [MEM_AW-1:0]  r_pc;
    logic [MEM_AW:0]    r_npc;
    logic [MEM_AW:0]    r_sp;
    logic [FILE_AW:0]   r_fri;
    logic [FILE_AW:0]   r_fwc;
    logic               r_zf, r_nf;
    logic [1:0]         r_run;
    logic [2:0]         r_fault;
    logic [REG_COUNT-1:0] r_rvalid;
    logic               r_rqv;
    logic [4:0]         r_op;
    logic [31:0]        r_a, r_b, r_ra;
    logic [MEM_AW-1:0]  r_clr;
    t_out               r_res;

    logic               mem_we;
    logic [MEM_AW-1:0]  mem_wa, mem_ra;
    logic [31:0]        mem_wd, mem_q;
    logic               file_we;
    logic [31:0]        file_q;
    logic               reg_we;
    logic [REG_AW-1:0]  reg_wa, reg_ra;
    logic [31:0]        reg_wd, reg_q, reg_val;

    rsm_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_wa), .i_wdata(mem_wd),
        .i_raddr(mem_ra), .o_rdata(mem_q)
    );
    rsm_ram #(.WIDTH(32), .DEPTH(FILE_DEPTH)) u_file (
        .i_clk(i_clk), .i_we(file_we), .i_waddr(r_fwc[FILE_AW-1:0]),
        .i_wdata(i_in.value), .i_raddr(r_fri[FILE_AW-1:0]), .o_rdata(file_q)
    );
    rsm_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_regs (
        .i_clk(i_clk), .i_we(reg_we), .i_waddr(reg_wa), .i_wdata(reg_wd),
        .i_raddr(reg_ra), .o_rdata(reg_q)
    );

    // A register never written since restart reads as zero.
    assign reg_val = r_rqv ? reg_q : 32'd0;
    assign reg_ra  = mem_q[REG_AW-1:0];

    function automatic logic in_mem(input logic signed [33:0] t);
        return !t[33] && (t < $signed(34'(MEM_DEPTH)));
    endfunction

    // Opcode fetch checks.
    logic [31:0]        pc32;
    logic [1:0]         inc;
    logic [2:0]         early_f;
    logic               op_ok;
    assign pc32  = 32'(r_pc);
    assign op_ok = (mem_q >= 32'd1) && (mem_q <= 32'(OPCODE_MAX));
    assign inc   = advance_of(mem_q[4:0]);
    always_comb begin
        if (pc32 >= 32'(MEM_DEPTH))                       early_f = F_PC;
        else if (!op_ok)                                  early_f = F_OPC;
        else if (33'(pc32) + 33'(inc) >= 33'(MEM_DEPTH))  early_f = F_PC;
        else                                              early_f = F_NONE;
    end

    // Execute stage.
    logic signed [33:0] npc_s, sp_s, spm1, spp1, ta, tb, tb_opb, tr;
    logic               a_bad, b_bad, take;
    logic [2:0]         f;
    logic               x_mem_we, x_reg_we, set_fl, fri_inc, emitted, halted;
    logic [33:0]        x_mem_wa;
    logic [31:0]        x_mem_wd, x_reg_wd, emit, alu;
    logic [MEM_AW:0]    sp_n, npc_n;

    assign npc_s  = 34'(r_npc);
    assign sp_s   = 34'(r_sp);
    assign spm1   = sp_s - 34'sd1;
    assign spp1   = sp_s + 34'sd1;
    assign ta     = npc_s + {{2{r_a[31]}}, r_a};
    assign tb     = npc_s + {{2{r_b[31]}}, r_b};
    assign tb_opb = npc_s + {{2{mem_q[31]}}, mem_q};
    assign tr     = {{2{mem_q[31]}}, mem_q};
    assign a_bad  = (r_a >= 32'(REG_COUNT));
    assign b_bad  = (r_b >= 32'(REG_COUNT));

    always_comb begin
        case (r_op)
            OP_COPY: alu = reg_val;
            OP_SUB:  alu = r_ra - reg_val;
            OP_ADD:  alu = r_ra + reg_val;
            OP_AND:  alu = r_ra & reg_val;
            OP_OR:   alu = r_ra | reg_val;
            OP_XOR:  alu = r_ra ^ reg_val;
            OP_NEG:  alu = 32'd0 - r_ra;
            default: alu = ~r_ra;
        endcase
        case (r_op)
            OP_JMP:  take = 1'b1;
            OP_JZ:   take = r_zf;
            OP_JNZ:  take = !r_zf;
            OP_JN:   take = r_nf;
            default: take = !r_nf;
        endcase
    end

    always_comb begin
        f        = F_NONE;
        x_mem_we = 1'b0;
        x_mem_wa = tb;
        x_mem_wd = r_ra;
        x_reg_we = 1'b0;
        x_reg_wd = alu;
        set_fl   = 1'b0;
        fri_inc  = 1'b0;
        emit     = 32'd0;
        emitted  = 1'b0;
        halted   = 1'b0;
        sp_n     = r_sp;
        npc_n    = r_npc;
        case (r_op)
            OP_LOAD, OP_STORE: begin
                if (a_bad) f = F_REG;
                else if (!in_mem(tb)) f = F_DADDR;
                else if (r_op == OP_LOAD) begin
                    x_reg_we = 1'b1;
                    x_reg_wd = mem_q;
                end else begin
                    x_mem_we = 1'b1;
                end
            end
            OP_READ: begin
                if (a_bad) f = F_REG;
                else if (r_fri >= r_fwc || 32'(r_fri) >= 32'(FILE_DEPTH)) f = F_FILE;
                else begin
                    x_reg_we = 1'b1;
                    x_reg_wd = file_q;
                    fri_inc  = 1'b1;
                end
            end
            OP_WRITE: begin
                if (a_bad) f = F_REG;
                else begin
                    emit    = r_ra;
                    emitted = 1'b1;
                end
            end
            OP_COPY, OP_SUB, OP_ADD, OP_AND, OP_OR, OP_XOR: begin
                if (a_bad || b_bad) f = F_REG;
                else begin
                    x_reg_we = 1'b1;
                    set_fl   = 1'b1;
                end
            end
            OP_NEG, OP_NOT: begin
                if (a_bad) f = F_REG;
                else begin
                    x_reg_we = 1'b1;
                    set_fl   = 1'b1;
                end
            end
            OP_JMP, OP_JZ, OP_JNZ, OP_JN, OP_JNN: begin
                if (take) begin
                    if (!in_mem(ta)) f = F_PC;
                    else npc_n = ta[MEM_AW:0];
                end
            end
            OP_PUSH: begin
                if (spm1 <= npc_s) f = F_STACK;
                else if (a_bad) f = F_REG;
                else begin
                    x_mem_we = 1'b1;
                    x_mem_wa = spm1;
                    sp_n     = spm1[MEM_AW:0];
                end
            end
            OP_POP: begin
                if (sp_s <= npc_s || spp1 >= $signed(34'(MEM_DEPTH))) f = F_STACK;
                else if (a_bad) f = F_REG;
                else begin
                    x_reg_we = 1'b1;
                    x_reg_wd = mem_q;
                    sp_n     = spp1[MEM_AW:0];
                end
            end
            OP_CALL: begin
                if (spm1 <= npc_s) f = F_STACK;
                else if (!in_mem(ta)) f = F_PC;
                else begin
                    x_mem_we = 1'b1;
                    x_mem_wa = spm1;
                    x_mem_wd = 32'(r_npc);
                    sp_n     = spm1[MEM_AW:0];
                    npc_n    = ta[MEM_AW:0];
                end
            end
            OP_RET: begin
                if (spp1 >= $signed(34'(MEM_DEPTH))) f = F_STACK;
                else if (!in_mem(tr)) f = F_PC;
                else begin
                    sp_n  = spp1[MEM_AW:0];
                    npc_n = tr[MEM_AW:0];
                end
            end
            default: halted = 1'b1;
        endcase
    end

    // Memory port steering.
    logic mem_addr_ok;
    assign mem_addr_ok = (32'(i_in.address) < 32'(MEM_DEPTH));
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = 32'd0;
        if (i_cmd.clear) begin
            mem_we = 1'b1;
        end else if (i_cmd.accept && i_in.operation == OPN_MEM_WR) begin
            mem_we = mem_addr_ok;
            mem_wa = i_in.address[MEM_AW-1:0];
            mem_wd = i_in.value;
        end else if (i_cmd.exec) begin
            mem_we = x_mem_we && (f == F_NONE);
            mem_wa = x_mem_wa[MEM_AW-1:0];
            mem_wd = x_mem_wd;
        end
        if (i_cmd.opc) begin
            mem_ra = r_pc + MEM_AW'(1);
        end else if (i_cmd.opa) begin
            mem_ra = (32'(r_npc) == 32'(r_pc) + 32'd3) ? r_pc + MEM_AW'(2) : r_pc;
        end else if (i_cmd.opb) begin
            mem_ra = (r_op == OP_LOAD || r_op == OP_STORE) ?
                     tb_opb[MEM_AW-1:0] : r_sp[MEM_AW-1:0];
        end else begin
            mem_ra = r_pc;
        end
    end

    assign file_we = i_cmd.accept && i_in.operation == OPN_FILE_WR &&
                     32'(r_fwc) < 32'(FILE_DEPTH);
    assign reg_we  = i_cmd.exec && x_reg_we && (f == F_NONE);
    assign reg_wa  = r_a[REG_AW-1:0];
    assign reg_wd  = x_reg_wd;

    assign o_stat.clr_done    = (32'(r_clr) == 32'(MEM_DEPTH - 1));
    assign o_stat.early_fault = (early_f != F_NONE);
    assign o_stat.running     = (r_run == RUN_RUNNING);
    assign o_out = r_res;

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_pc     <= '0;
            r_sp     <= (MEM_AW + 1)'(MEM_DEPTH - 1);
            r_fri    <= '0;
            r_fwc    <= '0;
            r_zf     <= 1'b0;
            r_nf     <= 1'b0;
            r_run    <= RUN_RUNNING;
            r_fault  <= F_NONE;
            r_rvalid <= '0;
        end else begin
            if (i_cmd.clear) r_clr <= r_clr + MEM_AW'(1);
            if (file_we) r_fwc <= r_fwc + (FILE_AW + 1)'(1);
            if (i_cmd.accept && i_in.operation == OPN_RESTART) begin
                r_pc     <= '0;
                r_sp     <= (MEM_AW + 1)'(MEM_DEPTH - 1);
                r_fri    <= '0;
                r_zf     <= 1'b0;
                r_nf     <= 1'b0;
                r_run    <= RUN_RUNNING;
                r_fault  <= F_NONE;
                r_rvalid <= '0;
            end
            if (i_cmd.opc && early_f != F_NONE) begin
                r_run   <= RUN_FAULTED;
                r_fault <= early_f;
            end
            if (i_cmd.exec) begin
                if (f != F_NONE) begin
                    r_run   <= RUN_FAULTED;
                    r_fault <= f;
                end else begin
                    r_pc <= npc_n[MEM_AW-1:0];
                    r_sp <= sp_n;
                    if (fri_inc) r_fri <= r_fri + (FILE_AW + 1)'(1);
                    if (set_fl) begin
                        r_zf <= (x_reg_wd == 32'd0);
                        r_nf <= x_reg_wd[31];
                    end
                    if (halted) r_run <= RUN_HALTED;
                    if (x_reg_we) r_rvalid[reg_wa] <= 1'b1;
                end
            end
        end
    end

    // Instruction words and result.
    logic [31:0] res_pc;
    t_out        n_res;
    assign res_pc = (f != F_NONE) ? pc32 : 32'(npc_n[MEM_AW-1:0]);

    always_comb begin
        n_res = r_res;
        if (i_cmd.accept) begin
            n_res = '0;
            n_res.program_counter = pc32[9:0];
            if (i_in.operation == OPN_RESTART) begin
                n_res.program_counter = 10'd0;
            end else if (i_in.operation == OPN_EXEC && r_run == RUN_FAULTED) begin
                n_res.status     = ST_FAULT;
                n_res.fault_code = r_fault;
            end else if (i_in.operation == OPN_EXEC && r_run == RUN_HALTED) begin
                n_res.status = ST_HALTED;
            end
        end
        if (i_cmd.opc && early_f != F_NONE) begin
            n_res.status     = ST_FAULT;
            n_res.fault_code = early_f;
        end
        if (i_cmd.exec) begin
            n_res.program_counter = res_pc[9:0];
            if (f != F_NONE) begin
                n_res.status     = ST_FAULT;
                n_res.fault_code = f;
            end else if (halted) begin
                n_res.status = ST_HALTED;
            end else if (emitted) begin
                n_res.status    = ST_OUTPUT;
                n_res.out_value = emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rqv <= r_rvalid[reg_ra];
        if (i_cmd.opc) begin
            r_op  <= mem_q[4:0];
            r_npc <= (MEM_AW + 1)'(r_pc) + (MEM_AW + 1)'(inc);
        end
        if (i_cmd.opa) r_a <= mem_q;
        if (i_cmd.opb) begin
            r_b  <= mem_q;
            r_ra <= reg_val;
        end
        r_res <= n_res;
    end
endmodule

[rtl/register_stack_machine_core.sv]
// Top level of the register stack machine core: controller plus datapath.
// Sequencing: an execute step runs from the accepted input beat through the fetch,
// opcode, first operand, second operand or data read, execute and output steps to
// the result beat, jumping to output when the opcode fetch faults; other operations,
// and execute steps while halted or faulted, answer in the next cycle. Only one beat
// is in flight: the next input beat is taken the cycle after the result beat is taken.
// Reset: synchronous, active low; a clearing pass then zeroes all of main memory.
module register_stack_machine_core
    import rsm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);
    // The controller walks each beat through the steps; the datapath holds all
    // architectural state, the three memories and the result register, which
    // stays stable while the result beat waits for the consumer.
    t_cmd  cmd;
    t_stat stat;

    rsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in.operation),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    rsm_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .o_stat  (stat),
        .o_out   (o_out)
    );
endmodule

[tb/tb_register_stack_machine_core.sv]
// Self-checking testbench for the register stack machine core.
`timescale 1ns / 100ps

module tb_register_stack_machine_core
    import rsm_pkg::*;
();

    // Cycles with no beat accepted on either side before the run is abandoned.
    // Covers the clearing pass after reset plus generous slack.
    localparam int WATCHDOG_LIMIT = 6000;

    // Scoreboard: a private copy of the machine state that predicts every
    // result beat, plus the queue of results still owed by the core.
    class machine_scoreboard;
        logic [31:0] mem_words [MEM_DEPTH];
        logic [31:0] file_words [FILE_DEPTH];
        logic [31:0] regs [REG_COUNT];
        int          pc;
        int          sp;
        int          file_rd;
        int          file_cnt;
        bit          zf;
        bit          nf;
        logic [1:0]  run_st;
        logic [2:0]  fault_latch;
        t_out        owed [$];
        int          errors;
        int          checked;
        int          faults_seen;
        int          writes_seen;

        function new();
            foreach (mem_words[i]) mem_words[i] = '0;
            foreach (file_words[i]) file_words[i] = '0;
            file_cnt = 0;
            errors = 0;
            checked = 0;
            faults_seen = 0;
            writes_seen = 0;
            restart_core();
        endfunction

        function void restart_core();
            foreach (regs[i]) regs[i] = '0;
            pc = 0;
            sp = MEM_DEPTH - 1;
            file_rd = 0;
            zf = 0;
            nf = 0;
            run_st = RUN_RUNNING;
            fault_latch = F_NONE;
        endfunction

        function void set_flags(logic [31:0] v);
            zf = (v == 0);
            nf = v[31];
        endfunction

        // Executes one instruction; returns the fault code, F_NONE when clean.
        // State is only touched once every check has passed, so a fault
        // leaves everything but the latch as it was.
        function logic [2:0] run_instruction(output logic [31:0] emit,
                                             output bit emitted, output bit halted);
            logic [31:0] opw;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] r;
            logic [4:0]  op;
            int          inc;
            int          npc;
            longint      t;
            bit          take;
            emit = '0;
            emitted = 0;
            halted = 0;
            a = '0;
            b = '0;
            if (pc >= MEM_DEPTH) return F_PC;
            opw = mem_words[pc];
            if (opw < 1 || opw > OPCODE_MAX) return F_OPC;
            op = opw[4:0];
            case (op)
                OP_LOAD, OP_STORE, OP_COPY, OP_SUB, OP_ADD, OP_AND, OP_OR,
                OP_XOR: inc = 3;
                OP_RET, OP_HALT: inc = 0;
                default: inc = 2;
            endcase
            if (pc + inc >= MEM_DEPTH) return F_PC;
            if (inc >= 1) a = mem_words[pc + 1];
            if (inc >= 3) b = mem_words[pc + 2];
            npc = pc + inc;
            case (op)
                OP_LOAD, OP_STORE: begin
                    if (a >= REG_COUNT) return F_REG;
                    t = longint'(npc) + longint'($signed(b));
                    if (t < 0 || t >= MEM_DEPTH) return F_DADDR;
                    if (op == OP_LOAD) regs[a] = mem_words[t];
                    else mem_words[t] = regs[a];
                end
                OP_READ: begin
                    if (a >= REG_COUNT) return F_REG;
                    if (file_rd >= file_cnt || file_rd >= FILE_DEPTH) return F_FILE;
                    regs[a] = file_words[file_rd];
                    file_rd++;
                end
                OP_WRITE: begin
                    if (a >= REG_COUNT) return F_REG;
                    emit = regs[a];
                    emitted = 1;
                end
                OP_COPY, OP_SUB, OP_ADD, OP_AND, OP_OR, OP_XOR: begin
                    if (a >= REG_COUNT || b >= REG_COUNT) return F_REG;
                    r = regs[a];
                    case (op)
                        OP_COPY: r = regs[b];
                        OP_SUB:  r = r - regs[b];
                        OP_ADD:  r = r + regs[b];
                        OP_AND:  r = r & regs[b];
                        OP_OR:   r = r | regs[b];
                        default: r = r ^ regs[b];
                    endcase
                    regs[a] = r;
                    set_flags(r);
                end
                OP_NEG, OP_NOT: begin
                    if (a >= REG_COUNT) return F_REG;
                    r = (op == OP_NEG) ? -regs[a] : ~regs[a];
                    regs[a] = r;
                    set_flags(r);
                end
                OP_JMP, OP_JZ, OP_JNZ, OP_JN, OP_JNN: begin
                    take = (op == OP_JMP) || (op == OP_JZ && zf) || (op == OP_JNZ && !zf)
                        || (op == OP_JN && nf) || (op == OP_JNN && !nf);
                    if (take) begin
                        t = longint'(npc) + longint'($signed(a));
                        if (t < 0 || t >= MEM_DEPTH) return F_PC;
                        npc = int'(t);
                    end
                end
                OP_PUSH: begin
                    if (sp - 1 <= npc) return F_STACK;
                    if (a >= REG_COUNT) return F_REG;
                    sp = sp - 1;
                    mem_words[sp] = regs[a];
                end
                OP_POP: begin
                    if (sp <= npc || sp >= MEM_DEPTH || sp + 1 >= MEM_DEPTH) return F_STACK;
                    if (a >= REG_COUNT) return F_REG;
                    regs[a] = mem_words[sp];
                    sp = sp + 1;
                end
                OP_CALL: begin
                    if (sp - 1 <= npc) return F_STACK;
                    t = longint'(npc) + longint'($signed(a));
                    if (t < 0 || t >= MEM_DEPTH) return F_PC;
                    sp = sp - 1;
                    mem_words[sp] = npc;
                    npc = int'(t);
                end
                OP_RET: begin
                    if (sp + 1 >= MEM_DEPTH) return F_STACK;
                    t = longint'($signed(mem_words[sp]));
                    if (t < 0 || t >= MEM_DEPTH) return F_PC;
                    sp = sp + 1;
                    npc = int'(t);
                end
                default: halted = 1;
            endcase
            pc = npc;
            return F_NONE;
        endfunction

        // Notes an accepted input beat and queues the result it must cause.
        function void note_input(t_in b);
            t_out        res;
            logic [2:0]  f;
            logic [31:0] emit;
            bit          emitted;
            bit          halted;
            res = '0;
            case (b.operation)
                OPN_MEM_WR: mem_words[b.address] = b.value;
                OPN_FILE_WR: begin
                    if (file_cnt < FILE_DEPTH) begin
                        file_words[file_cnt] = b.value;
                        file_cnt++;
                    end
                end
                OPN_RESTART: restart_core();
                default: begin
                    if (run_st == RUN_RUNNING) begin
                        f = run_instruction(emit, emitted, halted);
                        if (f != F_NONE) begin
                            run_st = RUN_FAULTED;
                            fault_latch = f;
                        end else if (halted) begin
                            run_st = RUN_HALTED;
                        end else if (emitted) begin
                            res.status = ST_OUTPUT;
                            res.out_value = emit;
                        end
                    end
                    if (run_st == RUN_FAULTED) begin
                        res.status = ST_FAULT;
                        res.fault_code = fault_latch;
                        res.out_value = '0;
                    end else if (run_st == RUN_HALTED) begin
                        res.status = ST_HALTED;
                        res.out_value = '0;
                    end
                end
            endcase
            res.program_counter = pc[9:0];
            owed.push_back(res);
        endfunction

        // Compares an accepted result beat with the oldest one owed.
        function void check_result(t_out got);
            t_out want;
            if (owed.size() == 0) begin
                $error("result beat with nothing expected: %p", got);
                errors++;
                return;
            end
            want = owed.pop_front();
            checked++;
            if (want.status == ST_FAULT) faults_seen++;
            if (want.status == ST_OUTPUT) writes_seen++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.fault_code !== want.fault_code) begin
                $error("fault_code: expected %0d, got %0d", want.fault_code, got.fault_code);
                errors++;
            end
            if (got.out_value !== want.out_value) begin
                $error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
                errors++;
            end
            if (got.program_counter !== want.program_counter) begin
                $error("program_counter: expected %0d, got %0d",
                       want.program_counter, got.program_counter);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    machine_scoreboard sb;
    bit                rst_done;
    bit                idling_on;
    int                stall_left;
    int                quiet_cycles;
    int                beats_sent;
    logic [31:0]       prog_words [$];

    register_stack_machine_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Result side: checks every accepted result beat, throws in random
    // stall bursts while idling is enabled, and runs the no-progress watchdog.
    always @(posedge i_clk) begin
        if (rst_done) begin
            if (o_out_valid && i_out_ready) sb.check_result(o_out);
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 3) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offers one input beat and returns at the edge where it is accepted.
    // Valid stays high across back-to-back beats; a random idle burst
    // lowers it before the beat when idling is enabled.
    task automatic send_beat(input logic [1:0] opn, input logic [9:0] addr,
                             input logic [31:0] val);
        t_in b;
        b.operation = opn;
        b.address = addr;
        b.value = val;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(b);
        beats_sent++;
    endtask

    // Holds the input side off until every owed result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed.size() != 0) @(posedge i_clk);
    endtask

    // Loads the words of prog_words into memory starting at base.
    task automatic load_program(input int base);
        foreach (prog_words[i]) send_beat(OPN_MEM_WR, 10'(base + i), prog_words[i]);
        prog_words.delete();
    endtask

    task automatic run_steps(input int n);
        repeat (n) send_beat(OPN_EXEC, 10'($urandom), $urandom);
    endtask

    // A register operand: usually valid, now and then any word at all.
    function automatic logic [31:0] pick_reg();
        if ($urandom_range(0, 24) == 0) return $urandom;
        return $urandom_range(0, REG_COUNT - 1);
    endfunction

    // Appends one random instruction placed at address at; npc is the address after
    // it, used to aim LOAD and STORE data offsets mostly at sensible places.
    task automatic add_instruction(input int at);
        int          pick;
        int          npc;
        logic [31:0] opw;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            // Undefined opcodes: zero, a value from 23 to 25, or any random word.
            case ($urandom_range(0, 2))
                0: opw = 0;
                1: opw = $urandom_range(OPCODE_MAX + 1, 25);
                default: opw = $urandom;
            endcase
            prog_words.push_back(opw);
            return;
        end
        opw = (pick < 5) ? 32'(OP_HALT) : $urandom_range(OP_LOAD, OP_RET);
        prog_words.push_back(opw);
        case (opw[4:0])
            OP_LOAD, OP_STORE: begin
                npc = at + 3;
                prog_words.push_back(pick_reg());
                if ($urandom_range(0, 14) == 0) prog_words.push_back($urandom);
                else prog_words.push_back($urandom_range(600, 900) - npc);
            end
            OP_COPY, OP_SUB, OP_ADD, OP_AND, OP_OR, OP_XOR: begin
                prog_words.push_back(pick_reg());
                prog_words.push_back(pick_reg());
            end
            OP_JMP, OP_JZ, OP_JNZ, OP_JN, OP_JNN, OP_CALL: begin
                if ($urandom_range(0, 14) == 0) prog_words.push_back($urandom);
                else prog_words.push_back($urandom_range(0, 8) - 2);
            end
            OP_RET, OP_HALT: ;
            default: prog_words.push_back(pick_reg());
        endcase
    endtask

    initial begin
        int n;
        int base;
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        rst_done = 0;
        idling_on = 1;
        stall_left = 0;
        quiet_cycles = 0;
        beats_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1;

        // Directed: executing zeroed memory faults with a bad opcode and the
        // latch sticks until a restart.
        run_steps(2);
        send_beat(OPN_RESTART, '1, '1);
        // READ with no file loaded faults with file.
        prog_words = '{32'(OP_READ), 32'd0};
        load_program(0);
        run_steps(1);
        send_beat(OPN_RESTART, '0, '0);
        // Extremes of the file word, read back and emitted, then HALT holds.
        send_beat(OPN_FILE_WR, '1, 32'h8000_0000);
        send_beat(OPN_FILE_WR, '0, 32'h7FFF_FFFF);
        prog_words = '{32'(OP_READ), 32'd3, 32'(OP_WRITE), 32'd3, 32'(OP_READ), 32'd4,
                       32'(OP_ADD), 32'd3, 32'd4, 32'(OP_WRITE), 32'd3, 32'(OP_HALT)};
        load_program(0);
        run_steps(7);
        // Operand words running past the end of memory fault with pc range.
        send_beat(OPN_RESTART, '0, '0);
        prog_words = '{32'(OP_JMP), 32'd1020};
        load_program(0);
        send_beat(OPN_MEM_WR, 10'd1022, 32'(OP_ADD));
        run_steps(2);
        send_beat(OPN_MEM_WR, 10'd1023, 32'hFFFF_FFFF);
        wait_drained();

        // Random programs: mostly well-formed instruction streams with random
        // content, with the file topped up, the odd stray data word, and
        // restarts that keep memory and the file.
        while (beats_sent < 440) begin
            if (beats_sent > 360) idling_on = 0;
            base = $urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : 0;
            send_beat(OPN_RESTART, 10'($urandom), $urandom);
            n = $urandom_range(6, 14);
            for (int i = 0; i < n; i++) add_instruction(base + prog_words.size());
            if (base != 0) begin
                prog_words.push_front(base - 2);
                prog_words.push_front(32'(OP_JMP));
                load_program(0);
            end else begin
                load_program(0);
            end
            repeat ($urandom_range(0, 4)) send_beat(OPN_FILE_WR, 10'($urandom), $urandom);
            repeat ($urandom_range(0, 3)) send_beat(OPN_MEM_WR, 10'($urandom), $urandom);
            send_beat(OPN_RESTART, 10'($urandom), $urandom);
            run_steps($urandom_range(6, 20));
            if ($urandom_range(0, 5) == 0) wait_drained();
        end

        // Fill the file past its depth so appends beyond it are dropped.
        while (sb.file_cnt < FILE_DEPTH) send_beat(OPN_FILE_WR, 10'($urandom), $urandom);
        repeat (3) send_beat(OPN_FILE_WR, 10'($urandom), $urandom);

        i_in_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.owed.size() != 0) begin
            $error("%0d results never arrived", sb.owed.size());
            sb.errors++;
        end
        $display("Covered %0d input beats and %0d result beats (%0d WRITE outputs, %0d faults).",
                 beats_sent, sb.checked, sb.writes_seen, sb.faults_seen);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/rsm_pkg.sv
rtl/rsm_ram.sv
rtl/rsm_ctrl.sv
rtl/rsm_dp.sv
rtl/register_stack_machine_core.sv
tb/tb_register_stack_machine_core.sv
